FILE: hdl/mmq_pkg.sv
// ----------------------------------------------------------------------------
// mmq_pkg
// Shared widths, types and helpers for the monotonic minimum queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mmq_pkg;

  // storage geometry
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;

  // fixed port field widths
  localparam int VALUE_W = 32;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [VALUE_W-1:0]    value_t;
  typedef logic [PTR_W-1:0]             ptr_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  // opcodes
  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic latch;       // capture a new request
    logic rd_tail;     // read the back entry
    logic rd_next;     // read the entry after the front
    logic drop;        // discard the back entry
    logic append;      // append or refuse the pushed value
    logic pop;         // pop the front if it matches
    logic load_front;  // take read data as the new front
    logic load_out;    // load the result register
  } mmq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic count_zero;  // deque holds no entries
    logic tail_gt;     // back entry greater than the request value
    logic pop_hit;     // front matches the request value
  } mmq_sts_t;

  // input value kept as a DATA_WIDTH signed number
  function automatic data_t fit_value(input value_t v);
    return DATA_WIDTH'(v);
  endfunction

  // stored value reported as a port field
  function automatic value_t report_value(input data_t d);
    return VALUE_W'(d);
  endfunction

  // circular slot at an offset from the head
  function automatic ptr_t slot_of(input ptr_t head, input cnt_t off);
    logic [PTR_W:0] sum;
    sum = (PTR_W+1)'(head) + (PTR_W+1)'(off);
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mmq_if.sv
// ----------------------------------------------------------------------------
// mmq_if
// Valid/ready channels for queue requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

// request channel
interface mmq_in_if import mmq_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   opcode;
  value_t value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

// result channel
interface mmq_out_if import mmq_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t min_value;
  logic   is_empty;
  logic   front_popped;
  logic   overflow;

  modport source (output valid, output min_value, output is_empty,
                  output front_popped, output overflow, input ready);
  modport sink   (input valid, input min_value, input is_empty,
                  input front_popped, input overflow, output ready);
endinterface

`default_nettype wire

FILE: hdl/monotonic_min_queue_core.sv
// A remove checks the front copy and, on a pop, loads the next entry as the new front;
// a push reads and compares the back entry, discards it while it is greater, then
// appends. A new request is taken only once the last result has been loaded.
// The back-entry scan through the single registered read port sets push time.
// Reset (rst_n, synchronous): deque empty, head 0, no result pending;
// the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
// monotonic_min_queue_core
// Minimum queue kept as a monotonic deque, one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

module monotonic_min_queue_core import mmq_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  mmq_in_if.sink    in_ch,
  mmq_out_if.source out_ch
);

  mmq_cmd_t cmd;
  mmq_sts_t sts;

  // sequencer
  mmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // storage and result
  mmq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_value         (in_ch.value),
    .out_min_value    (out_ch.min_value),
    .out_is_empty     (out_ch.is_empty),
    .out_front_popped (out_ch.front_popped),
    .out_overflow     (out_ch.overflow)
  );

endmodule

`default_nettype wire

FILE: hdl/mmq_ctrl.sv
// ----------------------------------------------------------------------------
// mmq_ctrl
// Sequencer for push and remove requests and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module mmq_ctrl import mmq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_opcode,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output mmq_cmd_t      cmd,
  input  wire mmq_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_CHK,
    ST_PUSH_CMP,
    ST_APPEND,
    ST_POP,
    ST_LOAD,
    ST_RESULT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // commands decoded from the state
  always_comb begin
    cmd            = '0;
    cmd.latch      = accept;
    cmd.rd_tail    = (state_r == ST_PUSH_CHK);
    cmd.drop       = (state_r == ST_PUSH_CMP) && sts.tail_gt;
    cmd.append     = (state_r == ST_APPEND);
    cmd.pop        = (state_r == ST_POP);
    cmd.rd_next    = (state_r == ST_POP);
    cmd.load_front = (state_r == ST_LOAD);
    cmd.load_out   = (state_r == ST_RESULT) && out_free;
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // result valid: set when a new result loads, cleared when taken
      if ((state_r == ST_RESULT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= (in_opcode == OP_PUSH) ? ST_PUSH_CHK : ST_POP;
          end
        end
        ST_PUSH_CHK: begin
          state_r <= sts.count_zero ? ST_APPEND : ST_PUSH_CMP;
        end
        ST_PUSH_CMP: begin
          state_r <= sts.tail_gt ? ST_PUSH_CHK : ST_APPEND;
        end
        ST_APPEND: begin
          state_r <= ST_RESULT;
        end
        ST_POP: begin
          state_r <= sts.pop_hit ? ST_LOAD : ST_RESULT;
        end
        ST_LOAD: begin
          state_r <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mmq_dp.sv
// ----------------------------------------------------------------------------
// mmq_dp
// Entry memory, head and count, front copy and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mmq_dp import mmq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mmq_cmd_t cmd,
  output mmq_sts_t      sts,
  input  wire value_t   in_value,
  output value_t        out_min_value,
  output logic          out_is_empty,
  output logic          out_front_popped,
  output logic          out_overflow
);

  data_t mem [DEPTH];

  ptr_t   head_r;
  cnt_t   count_r;
  data_t  value_r;
  data_t  front_r;
  data_t  rdata_r;
  logic   popped_r;
  logic   refused_r;
  value_t min_r;
  logic   empty_r;
  logic   popped_out_r;
  logic   refused_out_r;

  ptr_t   rd_addr;
  ptr_t   wr_addr;
  ptr_t   head_nxt;
  logic   full;
  logic   wr_en;

  assign full     = (count_r == cnt_t'(DEPTH));
  assign wr_addr  = slot_of(head_r, count_r);
  assign head_nxt = slot_of(head_r, cnt_t'(1));
  assign rd_addr  = cmd.rd_next ? head_nxt : slot_of(head_r, count_r - cnt_t'(1));
  assign wr_en    = cmd.append && !full;

  // status back to the controller
  assign sts.count_zero = (count_r == '0);
  assign sts.tail_gt    = (rdata_r > value_r);
  assign sts.pop_hit    = (count_r != '0) && (front_r == value_r);

  // entry memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value_r;
    end
    if (cmd.rd_tail || cmd.rd_next) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // head and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.drop) begin
      count_r <= count_r - cnt_t'(1);
    end else if (wr_en) begin
      count_r <= count_r + cnt_t'(1);
    end else if (cmd.pop && sts.pop_hit) begin
      head_r  <= head_nxt;
      count_r <= count_r - cnt_t'(1);
    end
  end

  // request capture, front copy and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      popped_r  <= 1'b0;
      refused_r <= 1'b0;
    end else if (cmd.latch) begin
      popped_r  <= 1'b0;
      refused_r <= 1'b0;
    end else if (cmd.append) begin
      refused_r <= full;
    end else if (cmd.pop) begin
      popped_r  <= sts.pop_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      value_r <= fit_value(in_value);
    end
    if (wr_en && (count_r == '0)) begin
      front_r <= value_r;
    end else if (cmd.load_front) begin
      front_r <= rdata_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      min_r         <= (count_r == '0) ? '0 : report_value(front_r);
      empty_r       <= (count_r == '0);
      popped_out_r  <= popped_r;
      refused_out_r <= refused_r;
    end
  end

  assign out_min_value    = min_r;
  assign out_is_empty     = empty_r;
  assign out_front_popped = popped_out_r;
  assign out_overflow     = refused_out_r;

endmodule

`default_nettype wire

FILE: test/monotonic_min_queue_core_tb.sv
// ----------------------------------------------------------------------------
// monotonic_min_queue_core_tb
// Checks the minimum queue one result per request. Directed requests cover
// extremes, equal values, misses and removes on an empty deque. Random runs
// then fill the deque to its limit and past it, slide windows and drain it.
// Requests arrive in bursts; the result side stalls and at times holds off
// long enough to back up the input. A local deque predicts every result.
// ----------------------------------------------------------------------------
`default_nettype none

module monotonic_min_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mmq_pkg::*;

  typedef struct packed {
    value_t min_value;
    logic   is_empty;
    logic   front_popped;
    logic   overflow;
  } minq_result_t;

  typedef struct packed {
    logic   opcode;
    value_t value;
  } minq_req_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  // two deque copies: one steers stimulus, one predicts results
  localparam int PLAN  = 0;
  localparam int MODEL = 1;

  localparam int RANDOM_REQS = 900;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 150;
  localparam int REQ_CAP     = 2048;

  localparam value_t VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam value_t VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  logic clk = 1'b0;
  logic rst_n;

  mmq_in_if  in_ch ();
  mmq_out_if out_ch ();

  monotonic_min_queue_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  data_t minq_slot  [2][DEPTH];
  int    minq_head  [2];
  int    minq_count [2];

  // pending requests and expected results, linear buffers with indexes
  minq_req_t    req_buf [REQ_CAP];
  minq_result_t exp_buf [REQ_CAP];
  int           req_wr = 0;
  int           req_rd = 0;
  int           exp_wr = 0;
  int           exp_rd = 0;

  int   planned = 0;
  int   errors = 0;
  int   checked = 0;
  int   n_push = 0, n_remove = 0, n_pops = 0, n_refused = 0, n_empty = 0;
  int   in_stalls = 0;
  logic req_taken = 1'b0;
  logic offering = 1'b0;
  int   gap_left = 0;
  int   burst_left = 1;
  int   rx_cycle = 0;
  int   hold_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // entry at an offset from the front
  function automatic data_t minq_at(input int k, input int off);
    return minq_slot[k][(minq_head[k] + off) % DEPTH];
  endfunction

  // one deque operation, returns the result it reports
  function automatic minq_result_t minq_step(input int k, input logic op, input value_t v);
    data_t        d;
    minq_result_t r;
    d = data_t'(v);
    r = '0;
    if (op == OP_PUSH) begin
      // discard strictly greater back entries
      while (minq_count[k] > 0 && minq_at(k, minq_count[k] - 1) > d) minq_count[k]--;
      if (minq_count[k] >= DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        minq_slot[k][(minq_head[k] + minq_count[k]) % DEPTH] = d;
        minq_count[k]++;
      end
    end else if (minq_count[k] > 0 && minq_at(k, 0) == d) begin
      minq_head[k] = (minq_head[k] + 1) % DEPTH;
      minq_count[k]--;
      r.front_popped = 1'b1;
    end
    r.is_empty  = (minq_count[k] == 0);
    r.min_value = r.is_empty ? '0 : value_t'(minq_at(k, 0));
    return r;
  endfunction

  // operand mix: extremes, a narrow band around zero, full range
  function automatic value_t rand_value();
    case ($urandom_range(0, 5))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3:    return value_t'($urandom_range(0, 40)) - value_t'(20);
      default: return value_t'($urandom);
    endcase
  endfunction

  task automatic add_req(input logic op, input value_t v);
    minq_req_t r;
    r.opcode = op;
    r.value  = v;
    if (req_wr < REQ_CAP) begin
      req_buf[req_wr] = r;
      req_wr++;
      void'(minq_step(PLAN, op, v));
      planned++;
    end else begin
      $display("%0t: request buffer exhausted", $time);
      $display("** monotonic_min_queue_core: FAILED **");
      $finish;
    end
  endtask

  function automatic void flag_mismatch(input string field, input value_t want,
                                        input value_t got);
    errors++;
    $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
             $time, field, want, want, got, got);
  endfunction

  // stimulus, reset and end of run
  initial begin
    int     n_directed;
    int     stepmax;
    value_t v;
    value_t base;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.opcode  = OP_PUSH;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;
    for (int k = 0; k < 2; k++) begin
      minq_head[k]  = 0;
      minq_count[k] = 0;
      for (int i = 0; i < DEPTH; i++) minq_slot[k][i] = '0;
    end

    // directed: empty removes, extremes, misses, equal values
    add_req(OP_REMOVE, '0);
    add_req(OP_PUSH, VAL_MAX);
    add_req(OP_REMOVE, '0);
    add_req(OP_PUSH, VAL_MIN);
    add_req(OP_PUSH, VAL_MIN);
    add_req(OP_REMOVE, VAL_MIN);
    add_req(OP_REMOVE, VAL_MIN);
    add_req(OP_REMOVE, VAL_MIN);
    add_req(OP_PUSH, -1);
    add_req(OP_PUSH, 0);
    add_req(OP_PUSH, 1);
    add_req(OP_PUSH, 0);
    add_req(OP_PUSH, 0);
    add_req(OP_REMOVE, -1);
    add_req(OP_REMOVE, 0);
    add_req(OP_REMOVE, 0);
    add_req(OP_REMOVE, 0);
    add_req(OP_PUSH, VAL_MAX);
    add_req(OP_PUSH, VAL_MAX);
    add_req(OP_REMOVE, VAL_MAX);
    add_req(OP_REMOVE, VAL_MAX);
    n_directed = planned;

    // random sequences steered by the planning copy
    while (planned < n_directed + RANDOM_REQS) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          // fill to the limit, push past it, then drain part way
          stepmax = $urandom_range(0, 3);
          v = rand_value();
          while (minq_count[PLAN] < DEPTH) begin
            add_req(OP_PUSH, v);
            if (v < VAL_MAX - 8) v = v + value_t'($urandom_range(0, stepmax));
          end
          repeat ($urandom_range(1, 3)) add_req(OP_PUSH, v);
          if ($urandom_range(0, 1)) add_req(OP_PUSH, rand_value());
          repeat ($urandom_range(10, 70)) begin
            if (minq_count[PLAN] > 0) add_req(OP_REMOVE, value_t'(minq_at(PLAN, 0)));
            else add_req(OP_REMOVE, rand_value());
          end
        end
        3, 4, 5, 6, 7, 8, 9, 10: begin
          // sliding window over a narrow band so removes hit
          base = rand_value();
          repeat ($urandom_range(20, 60)) begin
            if ($urandom_range(0, 9) < 6) begin
              add_req(OP_PUSH, base + value_t'($urandom_range(0, 16)));
            end else if (minq_count[PLAN] > 0 && $urandom_range(0, 4) != 0) begin
              add_req(OP_REMOVE, value_t'(minq_at(PLAN, 0)));
            end else begin
              add_req(OP_REMOVE, base + value_t'($urandom_range(0, 16)));
            end
          end
        end
        11, 12, 13, 14: begin
          // noise
          repeat ($urandom_range(5, 20))
            add_req($urandom_range(0, 1) ? OP_REMOVE : OP_PUSH, rand_value());
        end
        default: begin
          // drain to empty with some near-miss removes
          while (minq_count[PLAN] > 0) begin
            if ($urandom_range(0, 3) == 0) begin
              add_req(OP_REMOVE, value_t'(minq_at(PLAN, 0)) ^
                                 (value_t'(1) << $urandom_range(0, VALUE_W - 1)));
            end else begin
              add_req(OP_REMOVE, value_t'(minq_at(PLAN, 0)));
            end
          end
        end
      endcase
    end

    // reset
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // wait for all requests, all results, then a quiet tail
    while (req_rd != req_wr || offering) @(posedge clk);
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d pushes and %0d removes: %0d front pops,",
             n_push, n_remove, n_pops);
    $display("%0d refused pushes, %0d empty results, %0d checked, %0d input stall cycles",
             n_refused, n_empty, checked, in_stalls);
    if (errors == 0) begin
      $display("** monotonic_min_queue_core: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** monotonic_min_queue_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("** monotonic_min_queue_core: FAILED **");
    $finish;
  end

  // request driver: bursts with random gaps
  always @(negedge clk) begin : drive_requests
    minq_req_t cur;
    if (rst_n) begin
      if (req_taken) begin
        req_taken = 1'b0;
        offering  = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_rd < req_wr) begin
          cur          = req_buf[req_rd];
          req_rd++;
          in_ch.opcode = cur.opcode;
          in_ch.value  = cur.value;
          offering     = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end
      end
      in_ch.valid = offering;
    end
  end

  // result side stall pattern with occasional long hold-offs
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle == 600 || rx_cycle == 4000) hold_left = HOLD_CYCLES;
      if (rx_cycle % 200 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   out_ch.ready = 1'b1;
          RX_COIN:   out_ch.ready = 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready = (rx_cycle % 5 == 0);
          default:   out_ch.ready = ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin : check_results
    minq_result_t exp_r;
    minq_result_t act_r;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        exp_r = minq_step(MODEL, in_ch.opcode, in_ch.value);
        exp_buf[exp_wr] = exp_r;
        exp_wr++;
        req_taken = 1'b1;
        if (in_ch.opcode == OP_PUSH) n_push++;
        else n_remove++;
        if (exp_r.front_popped) n_pops++;
        if (exp_r.overflow) n_refused++;
        if (exp_r.is_empty) n_empty++;
      end else if (in_ch.valid) begin
        in_stalls++;
      end

      if (out_ch.valid && out_ch.ready) begin
        act_r.min_value    = out_ch.min_value;
        act_r.is_empty     = out_ch.is_empty;
        act_r.front_popped = out_ch.front_popped;
        act_r.overflow     = out_ch.overflow;
        if (exp_rd == exp_wr) begin
          errors++;
          $display("%0t: unrequested result, min %0d empty %b popped %b ovf %b",
                   $time, act_r.min_value, act_r.is_empty, act_r.front_popped,
                   act_r.overflow);
        end else begin
          exp_r = exp_buf[exp_rd];
          exp_rd++;
          checked++;
          if (act_r.min_value !== exp_r.min_value)
            flag_mismatch("min_value", exp_r.min_value, act_r.min_value);
          if (act_r.is_empty !== exp_r.is_empty)
            flag_mismatch("is_empty", value_t'(exp_r.is_empty), value_t'(act_r.is_empty));
          if (act_r.front_popped !== exp_r.front_popped)
            flag_mismatch("front_popped", value_t'(exp_r.front_popped),
                          value_t'(act_r.front_popped));
          if (act_r.overflow !== exp_r.overflow)
            flag_mismatch("overflow", value_t'(exp_r.overflow), value_t'(act_r.overflow));
        end
      end
    end
  end

endmodule

`default_nettype wire
